// ===== rtl/dmx_pkg.sv =====
// Shared constants, message codes and controller/datapath link types
// for the distributed mutex node. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmx_pkg;

   localparam int unsigned INDEX_WIDTH      = 5;
   localparam int unsigned NODE_COUNT_WIDTH = 6;
   localparam int unsigned SEQ_WIDTH        = 32;
   localparam int unsigned TYPE_WIDTH       = 3;
   localparam int unsigned KIND_WIDTH       = 3;
   localparam int unsigned TDATA_WIDTH      = 40;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH   = 6;

   localparam logic [TYPE_WIDTH-1:0] REQ_CLIENT_REQUEST  = 3'd0;
   localparam logic [TYPE_WIDTH-1:0] REQ_PEER_PERMIT     = 3'd1;
   localparam logic [TYPE_WIDTH-1:0] REQ_PEER_REQUEST    = 3'd2;
   localparam logic [TYPE_WIDTH-1:0] REQ_CLIENT_RELEASE  = 3'd3;
   localparam logic [TYPE_WIDTH-1:0] REQ_CLIENT_FINISHED = 3'd4;
   localparam logic [TYPE_WIDTH-1:0] REQ_PEER_LEAVING    = 3'd5;

   localparam logic [KIND_WIDTH-1:0] KIND_GRANT    = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_REQUEST  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_PERMIT   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_LEAVING  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_FINISHED = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OWN_INDEX  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_COUNT = 1'b1;

   typedef struct packed {
      logic load;
      logic emit_lead;
      logic emit_scan;
      logic emit_tail;
   } dmx_cmd_type;

   typedef struct packed {
      logic has_lead;
      logic scan_nz;
      logic has_tail;
      logic out_free;
   } dmx_status_type;

endpackage

`default_nettype wire

// ===== rtl/dmx_ctrl.sv =====
// Sequencing state machine: accept an item, then issue the leading result,
// the per-peer scan and the trailing result. Depends on dmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmx_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  dmx_pkg::dmx_status_type status,
   output dmx_pkg::dmx_cmd_type    cmd
);
   import dmx_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEAD = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_TAIL = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            if (!status.has_lead) begin
               state_in = ST_SCAN;
            end else if (status.out_free) begin
               cmd.emit_lead = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.scan_nz) begin
               state_in = ST_TAIL;
            end else if (status.out_free) begin
               cmd.emit_scan = 1'b1;
            end
         end
         ST_TAIL: begin
            if (!status.has_tail) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dmx_dp.sv =====
// Node state, configuration registers, peer scan mask and result register.
// Driven by dmx_ctrl commands. Depends on dmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmx_dp #(
   parameter int unsigned MAX_NODES = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic [dmx_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [dmx_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   input  logic [dmx_pkg::TYPE_WIDTH-1:0]          req_type,
   input  logic [dmx_pkg::INDEX_WIDTH-1:0]         source_node,
   input  logic [dmx_pkg::SEQ_WIDTH-1:0]           seq_in,
   input  dmx_pkg::dmx_cmd_type                    cmd,
   output dmx_pkg::dmx_status_type                 status,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [dmx_pkg::KIND_WIDTH-1:0]          msg_kind,
   output logic [dmx_pkg::INDEX_WIDTH-1:0]         dest_node,
   output logic [dmx_pkg::SEQ_WIDTH-1:0]           seq_out,
   output logic                                    last
);
   import dmx_pkg::*;

   logic [INDEX_WIDTH-1:0]      own_index_ff;
   logic [NODE_COUNT_WIDTH-1:0] node_count_ff;

   logic                        local_pending_ff, local_pending_in;
   logic                        wants_exit_ff, wants_exit_in;
   logic                        finished_ff, finished_in;
   logic [SEQ_WIDTH-1:0]        highest_seq_ff, highest_seq_in;
   logic [SEQ_WIDTH-1:0]        own_seq_ff, own_seq_in;
   logic [NODE_COUNT_WIDTH-1:0] permits_ff, permits_in;
   logic [MAX_NODES-1:0]        deferred_ff, deferred_in;
   logic [NODE_COUNT_WIDTH-1:0] left_ff, left_in;

   logic                        lead_ff, lead_in;
   logic [KIND_WIDTH-1:0]       lead_kind_ff, lead_kind_in;
   logic [INDEX_WIDTH-1:0]      lead_dest_ff, lead_dest_in;
   logic [MAX_NODES-1:0]        scan_ff, scan_in;
   logic [KIND_WIDTH-1:0]       scan_kind_ff, scan_kind_in;
   logic                        tail_ff, tail_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KIND_WIDTH-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [INDEX_WIDTH-1:0]      rsp_dest_ff, rsp_dest_in;
   logic [SEQ_WIDTH-1:0]        rsp_seq_ff, rsp_seq_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [NODE_COUNT_WIDTH-1:0] active_cnt;
   logic [NODE_COUNT_WIDTH-1:0] cnt_minus_one;
   logic [MAX_NODES-1:0]        below_mask;
   logic [MAX_NODES-1:0]        own_mask;
   logic [MAX_NODES-1:0]        src_mask;
   logic [MAX_NODES-1:0]        scan_low;
   logic [MAX_NODES-1:0]        scan_rest;
   logic [MAX_NODES-1:0]        others_mask;
   logic [INDEX_WIDTH-1:0]      scan_dest;
   logic [SEQ_WIDTH-1:0]        highest_inc;
   logic [NODE_COUNT_WIDTH-1:0] left_inc;
   logic                        defer_wins;
   logic                        src_in_range;
   logic                        out_free;

   always_comb begin
      if (node_count_ff == '0) begin
         active_cnt = NODE_COUNT_WIDTH'(1);
      end else if (node_count_ff > NODE_COUNT_WIDTH'(MAX_NODES)) begin
         active_cnt = NODE_COUNT_WIDTH'(MAX_NODES);
      end else begin
         active_cnt = node_count_ff;
      end
   end

   assign cnt_minus_one = active_cnt - NODE_COUNT_WIDTH'(1);

   for (genvar n = 0; n < MAX_NODES; n++) begin : g_masks
      assign below_mask[n] = NODE_COUNT_WIDTH'(n) < active_cnt;
      assign own_mask[n]   = own_index_ff == INDEX_WIDTH'(n);
      assign src_mask[n]   = source_node == INDEX_WIDTH'(n);
   end

   assign others_mask = below_mask & ~own_mask;
   assign scan_low    = scan_ff & (~scan_ff + MAX_NODES'(1));
   assign scan_rest   = scan_ff & ~scan_low;

   always_comb begin
      scan_dest = '0;
      for (int n = 0; n < MAX_NODES; n++) begin
         if (scan_low[n]) begin
            scan_dest = scan_dest | INDEX_WIDTH'(n);
         end
      end
   end

   assign highest_inc  = (highest_seq_ff == '1) ? highest_seq_ff
                                                : highest_seq_ff + SEQ_WIDTH'(1);
   assign left_inc     = (left_ff == '1) ? left_ff : left_ff + NODE_COUNT_WIDTH'(1);
   assign defer_wins   = (own_seq_ff < seq_in)
                         || ((own_seq_ff == seq_in) && (own_index_ff < source_node));
   assign src_in_range = {1'b0, source_node} < active_cnt;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      local_pending_in = local_pending_ff;
      wants_exit_in    = wants_exit_ff;
      finished_in      = finished_ff;
      highest_seq_in   = highest_seq_ff;
      own_seq_in       = own_seq_ff;
      permits_in       = permits_ff;
      deferred_in      = deferred_ff;
      left_in          = left_ff;
      lead_in          = lead_ff;
      lead_kind_in     = lead_kind_ff;
      lead_dest_in     = lead_dest_ff;
      scan_in          = scan_ff;
      scan_kind_in     = scan_kind_ff;
      tail_in          = tail_ff;

      if (cmd.load) begin
         lead_in      = 1'b0;
         lead_kind_in = KIND_GRANT;
         lead_dest_in = '0;
         scan_in      = '0;
         scan_kind_in = KIND_PERMIT;
         tail_in      = 1'b0;
         if (!finished_ff) begin
            unique case (req_type)
               REQ_CLIENT_REQUEST: begin
                  local_pending_in = 1'b1;
                  highest_seq_in   = highest_inc;
                  own_seq_in       = highest_inc;
                  permits_in       = cnt_minus_one;
                  lead_in          = cnt_minus_one == '0;
                  scan_in          = others_mask;
                  scan_kind_in     = KIND_REQUEST;
               end
               REQ_PEER_PERMIT: begin
                  if (permits_ff != '0) begin
                     permits_in = permits_ff - NODE_COUNT_WIDTH'(1);
                     lead_in    = permits_ff == NODE_COUNT_WIDTH'(1);
                  end
               end
               REQ_PEER_REQUEST: begin
                  if (local_pending_ff && !wants_exit_ff && defer_wins && src_in_range) begin
                     deferred_in = deferred_ff | src_mask;
                  end else begin
                     lead_in      = 1'b1;
                     lead_kind_in = KIND_PERMIT;
                     lead_dest_in = source_node;
                  end
                  if (seq_in > highest_seq_ff) begin
                     highest_seq_in = seq_in;
                  end
               end
               REQ_CLIENT_RELEASE: begin
                  local_pending_in = 1'b0;
                  scan_in          = deferred_ff & below_mask;
                  deferred_in      = deferred_ff & ~below_mask;
               end
               REQ_CLIENT_FINISHED: begin
                  scan_in       = others_mask;
                  scan_kind_in  = KIND_LEAVING;
                  deferred_in   = deferred_ff & ~others_mask;
                  wants_exit_in = 1'b1;
                  if (left_ff == cnt_minus_one) begin
                     finished_in = 1'b1;
                     tail_in     = 1'b1;
                  end
               end
               REQ_PEER_LEAVING: begin
                  left_in = left_inc;
                  if ((left_inc == cnt_minus_one) && wants_exit_ff) begin
                     finished_in  = 1'b1;
                     lead_in      = 1'b1;
                     lead_kind_in = KIND_FINISHED;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.emit_lead) begin
         lead_in = 1'b0;
      end
      if (cmd.emit_scan) begin
         scan_in = scan_rest;
      end
      if (cmd.emit_tail) begin
         tail_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_lead) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = lead_kind_ff;
         rsp_dest_in  = lead_dest_ff;
         rsp_seq_in   = '0;
         rsp_last_in  = (scan_ff == '0) && !tail_ff;
      end else if (cmd.emit_scan) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = scan_kind_ff;
         rsp_dest_in  = scan_dest;
         rsp_seq_in   = (scan_kind_ff == KIND_REQUEST) ? own_seq_ff : '0;
         rsp_last_in  = (scan_rest == '0) && !tail_ff;
      end else if (cmd.emit_tail) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_FINISHED;
         rsp_dest_in  = '0;
         rsp_seq_in   = '0;
         rsp_last_in  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_index_ff     <= '0;
         node_count_ff    <= NODE_COUNT_WIDTH'(8);
         local_pending_ff <= 1'b0;
         wants_exit_ff    <= 1'b0;
         finished_ff      <= 1'b0;
         highest_seq_ff   <= '0;
         own_seq_ff       <= '0;
         permits_ff       <= NODE_COUNT_WIDTH'(1);
         deferred_ff      <= '0;
         left_ff          <= '0;
         lead_ff          <= 1'b0;
         scan_ff          <= '0;
         tail_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_OWN_INDEX:  own_index_ff  <= csr_data[INDEX_WIDTH-1:0];
               CSR_NODE_COUNT: node_count_ff <= csr_data;
               default: begin
               end
            endcase
         end
         local_pending_ff <= local_pending_in;
         wants_exit_ff    <= wants_exit_in;
         finished_ff      <= finished_in;
         highest_seq_ff   <= highest_seq_in;
         own_seq_ff       <= own_seq_in;
         permits_ff       <= permits_in;
         deferred_ff      <= deferred_in;
         left_ff          <= left_in;
         lead_ff          <= lead_in;
         scan_ff          <= scan_in;
         tail_ff          <= tail_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_kind_ff <= lead_kind_in;
      lead_dest_ff <= lead_dest_in;
      scan_kind_ff <= scan_kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.has_lead = lead_ff;
   assign status.scan_nz  = scan_ff != '0;
   assign status.has_tail = tail_ff;
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign msg_kind  = rsp_kind_ff;
   assign dest_node = rsp_dest_ff;
   assign seq_out   = rsp_seq_ff;
   assign last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/distributed_mutex_node_unit.sv =====
// Distributed mutex node: one item at a time; a new item is not accepted
// until all results of the previous item have been issued.
// An item yields P per-peer results (at most MAX_NODES) from the peer scan,
// one a cycle while the output is not stalled.
// Reset (synchronous, active high) clears the node state but sets permits to 1,
// sets own_index to 0 and node_count to 8. Depends on dmx_pkg, dmx_ctrl and dmx_dp.
`timescale 1ns / 1ps
`default_nettype none

module distributed_mutex_node_unit #(
   parameter int unsigned MAX_NODES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmx_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dmx_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dmx_pkg::TDATA_WIDTH-1:0]      req_tdata,  // source_node, seq_in
   input  logic [dmx_pkg::TYPE_WIDTH-1:0]       req_tuser,  // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dmx_pkg::TDATA_WIDTH-1:0]      rsp_tdata,  // dest_node, seq_out
   output logic [dmx_pkg::KIND_WIDTH-1:0]       rsp_tuser,  // msg_kind
   output logic                                 rsp_tlast
);
   import dmx_pkg::*;

   dmx_cmd_type            cmd;
   dmx_status_type         status;
   logic [INDEX_WIDTH-1:0] dest_node;
   logic [SEQ_WIDTH-1:0]   seq_out;

   assign csr_ready = 1'b1;

   dmx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dmx_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_type    (req_tuser),
      .source_node (req_tdata[INDEX_WIDTH-1:0]),
      .seq_in      (req_tdata[INDEX_WIDTH+SEQ_WIDTH-1:INDEX_WIDTH]),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .msg_kind    (rsp_tuser),
      .dest_node   (dest_node),
      .seq_out     (seq_out),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {(TDATA_WIDTH - INDEX_WIDTH - SEQ_WIDTH)'(0), seq_out, dest_node};

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.emit_lead, cmd.emit_scan, cmd.emit_tail}))
      else $error("controller issued more than one command");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lead || cmd.emit_scan || cmd.emit_tail) |-> status.out_free)
      else $error("result issued while output register is occupied");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready)
         |-> !(status.has_lead || status.scan_nz || status.has_tail))
      else $error("item accepted with results of the previous item outstanding");

endmodule

`default_nettype wire

// ===== test/distributed_mutex_node_unit_tb.sv =====
// Self-checking testbench for distributed_mutex_node_unit: drives peer and client
// messages, mostly with random gaps, and checks every emitted message against a behavioural
// predictor of the node. Depends on dmx_pkg and the node RTL.
`timescale 1ns / 1ps

module distributed_mutex_node_unit_tb;

   import dmx_pkg::*;

   localparam int unsigned NODE_LIMIT    = 8;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam logic [TYPE_WIDTH-1:0] REQ_RESERVED_A = 3'd6;
   localparam logic [TYPE_WIDTH-1:0] REQ_RESERVED_B = 3'd7;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0]  op;
      logic [INDEX_WIDTH-1:0] src;
      logic [SEQ_WIDTH-1:0]   seq;
   } node_input_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [INDEX_WIDTH-1:0] dest;
      logic [SEQ_WIDTH-1:0]   seq;
      logic                   tail;
   } node_msg_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data   = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [TDATA_WIDTH-1:0]      req_tdata  = '0;
   logic [TYPE_WIDTH-1:0]       req_tuser  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0]      rsp_tdata;
   logic [KIND_WIDTH-1:0]       rsp_tuser;
   logic                        rsp_tlast;

   node_input_type item_fifo[$];
   node_msg_type   expected_msgs[$];
   logic        req_took   = 1'b0;
   logic        no_gaps    = 1'b0;
   int unsigned fail_count = 0;
   int unsigned csr_writes = 0;
   int unsigned planned    = 0;

   // predictor state
   logic [INDEX_WIDTH-1:0]      cfg_own_index = '0;
   logic [NODE_COUNT_WIDTH-1:0] cfg_node_count = 6'd8;
   logic                        pending_local = 1'b0;
   logic                        exit_wanted   = 1'b0;
   logic                        node_done     = 1'b0;
   logic [SEQ_WIDTH-1:0]        seq_high      = '0;
   logic [SEQ_WIDTH-1:0]        seq_own       = '0;
   logic [5:0]                  permits_owed  = 6'd1;
   logic [NODE_LIMIT-1:0]       deferred      = '0;
   logic [5:0]                  left_peers    = '0;

   // stimulus planning state
   logic [SEQ_WIDTH-1:0] gen_high = '0;
   logic [SEQ_WIDTH-1:0] gen_mine = '0;
   int unsigned          gen_cnt  = 8;

   distributed_mutex_node_unit #(.MAX_NODES(NODE_LIMIT)) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic node_msg_type make_msg(input logic [KIND_WIDTH-1:0] kind,
                                             input logic [INDEX_WIDTH-1:0] dest,
                                             input logic [SEQ_WIDTH-1:0] seq);
      node_msg_type m;
      m.kind = kind;
      m.dest = dest;
      m.seq  = seq;
      m.tail = 1'b0;
      return m;
   endfunction

   task automatic predict_node(input node_input_type it);
      node_msg_type batch[$];
      int unsigned  active;
      int           n;
      active = cfg_node_count;
      if (active < 1) active = 1;
      if (active > NODE_LIMIT) active = NODE_LIMIT;
      if (node_done) return;
      case (it.op)
         REQ_CLIENT_REQUEST: begin
            pending_local = 1'b1;
            if (seq_high != '1) seq_high = seq_high + 32'd1;
            seq_own = seq_high;
            permits_owed = 6'(active - 1);
            if (permits_owed == 0) batch.push_back(make_msg(KIND_GRANT, '0, '0));
            for (n = 0; n < active; n++)
               if (n != cfg_own_index) batch.push_back(make_msg(KIND_REQUEST, 5'(n), seq_own));
         end
         REQ_PEER_PERMIT: begin
            if (permits_owed != 0) begin
               permits_owed = permits_owed - 6'd1;
               if (permits_owed == 0) batch.push_back(make_msg(KIND_GRANT, '0, '0));
            end
         end
         REQ_PEER_REQUEST: begin
            if (!pending_local || exit_wanted) begin
               batch.push_back(make_msg(KIND_PERMIT, it.src, '0));
            end else if ((seq_own < it.seq || (seq_own == it.seq && cfg_own_index < it.src))
                         && it.src < active) begin
               deferred[it.src] = 1'b1;
            end else begin
               batch.push_back(make_msg(KIND_PERMIT, it.src, '0));
            end
            if (it.seq > seq_high) seq_high = it.seq;
         end
         REQ_CLIENT_RELEASE: begin
            pending_local = 1'b0;
            for (n = 0; n < active; n++) begin
               if (deferred[n]) begin
                  deferred[n] = 1'b0;
                  batch.push_back(make_msg(KIND_PERMIT, 5'(n), '0));
               end
            end
         end
         REQ_CLIENT_FINISHED: begin
            for (n = 0; n < active; n++) begin
               if (n != cfg_own_index) begin
                  deferred[n] = 1'b0;
                  batch.push_back(make_msg(KIND_LEAVING, 5'(n), '0));
               end
            end
            exit_wanted = 1'b1;
            if (left_peers == active - 1) begin
               node_done = 1'b1;
               batch.push_back(make_msg(KIND_FINISHED, '0, '0));
            end
         end
         REQ_PEER_LEAVING: begin
            if (left_peers < 63) left_peers = left_peers + 6'd1;
            if (left_peers == active - 1 && exit_wanted) begin
               node_done = 1'b1;
               batch.push_back(make_msg(KIND_FINISHED, '0, '0));
            end
         end
         default: ;
      endcase
      if (batch.size() != 0) batch[batch.size() - 1].tail = 1'b1;
      foreach (batch[i]) expected_msgs.push_back(batch[i]);
   endtask

   always @(negedge clock) begin : feed
      node_input_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (item_fifo.size() != 0 && (no_gaps || $urandom_range(99) >= 32)) begin
            it = item_fifo.pop_front();
            req_tuser  <= it.op;
            req_tdata  <= {3'b000, it.seq, it.src};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && (no_gaps || $urandom_range(99) >= 32);
   end

   always @(posedge clock) begin : observe
      node_input_type taken;
      node_msg_type   got;
      node_msg_type   want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OWN_INDEX) cfg_own_index = csr_data[INDEX_WIDTH-1:0];
            else cfg_node_count = csr_data;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            taken.op  = req_tuser;
            taken.src = req_tdata[4:0];
            taken.seq = req_tdata[36:5];
            predict_node(taken);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.dest = rsp_tdata[4:0];
            got.seq  = rsp_tdata[36:5];
            got.tail = rsp_tlast;
            if (expected_msgs.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected message: kind %0d dest %0d seq %h last %b",
                           got.kind, got.dest, got.seq, got.tail);
               fail_count++;
            end else begin
               want = expected_msgs.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected kind %0d dest %0d seq %h last %b,",
                              want.kind, want.dest, want.seq, want.tail,
                              " got kind %0d dest %0d seq %h last %b",
                              got.kind, got.dest, got.seq, got.tail);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic plan_item(input logic [TYPE_WIDTH-1:0] op, input logic [INDEX_WIDTH-1:0] src,
                            input logic [SEQ_WIDTH-1:0] seq);
      node_input_type it;
      it.op  = op;
      it.src = src;
      it.seq = seq;
      item_fifo.push_back(it);
      if (op == REQ_CLIENT_REQUEST) begin
         if (gen_high != '1) gen_high = gen_high + 32'd1;
         gen_mine = gen_high;
      end
      if (op == REQ_PEER_REQUEST && seq > gen_high) gen_high = seq;
      if (op != REQ_RESERVED_A && op != REQ_RESERVED_B) planned++;
   endtask

   function automatic logic [SEQ_WIDTH-1:0] pick_peer_seq();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return $urandom;
      if (roll < 30 && gen_mine != 0) return gen_mine - 32'd1;
      if (roll < 55) return gen_mine;
      if (roll < 80 && gen_mine != '1) return gen_mine + 32'd1;
      if (gen_mine > 32'hFFFF_FF00) return gen_mine;
      return gen_mine + $urandom_range(200, 2);
   endfunction

   function automatic logic [INDEX_WIDTH-1:0] pick_peer();
      if ($urandom_range(99) < 85) return 5'($urandom_range(gen_cnt - 1));
      return 5'($urandom_range(31));
   endfunction

   task automatic plan_round();
      int unsigned owed;
      int unsigned extra;
      if ($urandom_range(3) == 0) plan_item(REQ_PEER_REQUEST, pick_peer(), pick_peer_seq());
      plan_item(REQ_CLIENT_REQUEST, 5'($urandom_range(31)), $urandom);
      owed = gen_cnt - 1;
      case ($urandom_range(9))
         0: owed = owed + 1;
         1: if (owed != 0) owed = owed - 1;
         default: ;
      endcase
      extra = $urandom_range(3);
      while (owed + extra != 0) begin
         if (extra != 0 && (owed == 0 || $urandom_range(1) == 1)) begin
            plan_item(REQ_PEER_REQUEST, pick_peer(), pick_peer_seq());
            extra--;
         end else begin
            plan_item(REQ_PEER_PERMIT, 5'($urandom_range(31)), $urandom);
            owed--;
         end
      end
      if ($urandom_range(9) != 0)
         plan_item(REQ_CLIENT_RELEASE, 5'($urandom_range(31)), $urandom);
   endtask

   task automatic plan_noise();
      logic [TYPE_WIDTH-1:0] op;
      case ($urandom_range(5))
         0: op = REQ_CLIENT_REQUEST;
         1: op = REQ_PEER_PERMIT;
         2: op = REQ_PEER_REQUEST;
         3: op = REQ_CLIENT_RELEASE;
         4: op = REQ_RESERVED_A;
         default: op = REQ_RESERVED_B;
      endcase
      plan_item(op, 5'($urandom_range(31)), $urandom);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      int unsigned target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      while (csr_writes != target) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int unsigned own, input int unsigned count);
      logic [CSR_DATA_WIDTH-1:0] value;
      value    = {1'b0, own[4:0]};
      value[5] = 1'($urandom_range(1));
      csr_write(CSR_OWN_INDEX, value);
      csr_write(CSR_NODE_COUNT, count[5:0]);
      gen_cnt = count;
      if (gen_cnt < 1) gen_cnt = 1;
      if (gen_cnt > NODE_LIMIT) gen_cnt = NODE_LIMIT;
   endtask

   // hold until every item is taken and every message has come out
   task automatic drain();
      while (item_fifo.size() != 0 || req_tvalid || expected_msgs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned own_pick[4];
      int unsigned count_pick[4];
      int unsigned own;
      int unsigned count;
      int unsigned start;
      own_pick   = '{31, 7, 3, 0};
      count_pick = '{0, 63, 1, 32};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan_item(REQ_RESERVED_A, 5'd31, '1);
      plan_item(REQ_RESERVED_B, 5'd0, '0);
      plan_item(REQ_PEER_PERMIT, 5'd0, '0);
      plan_item(REQ_PEER_PERMIT, 5'd31, '1);
      plan_item(REQ_CLIENT_RELEASE, 5'd31, '0);
      plan_item(REQ_PEER_REQUEST, 5'd31, '0);
      plan_item(REQ_CLIENT_REQUEST, 5'd0, '1);
      plan_item(REQ_PEER_REQUEST, 5'd5, 32'd1);
      plan_item(REQ_PEER_REQUEST, 5'd0, 32'd1);
      plan_item(REQ_PEER_REQUEST, 5'd3, 32'd2);
      plan_item(REQ_PEER_REQUEST, 5'd6, 32'd0);
      plan_item(REQ_PEER_REQUEST, 5'd9, 32'd5);
      plan_item(REQ_CLIENT_REQUEST, 5'd17, 32'h5555_5555);
      repeat (8) plan_item(REQ_PEER_PERMIT, 5'd10, 32'hAAAA_AAAA);
      plan_item(REQ_CLIENT_RELEASE, 5'd0, '0);
      plan_item(REQ_CLIENT_RELEASE, 5'd0, '0);
      drain();

      for (int p = 0; p < 8; p++) begin
         if (p < 4) begin
            own   = own_pick[p];
            count = count_pick[p];
         end else begin
            own   = ($urandom_range(99) < 30) ? $urandom_range(31) : $urandom_range(7);
            count = ($urandom_range(99) < 20) ? $urandom_range(63) : $urandom_range(8, 2);
         end
         set_config(own, count);
         no_gaps = (p == 5);
         start = planned;
         while (planned - start < 32) begin
            if ($urandom_range(4) == 0) plan_noise();
            else plan_round();
         end
         drain();
         no_gaps = 1'b0;
      end

      // saturate the sequence numbers, then wind the node down
      set_config(2, 5);
      plan_item(REQ_PEER_REQUEST, 5'd1, '1);
      plan_round();
      plan_item(REQ_CLIENT_REQUEST, 5'd0, '0);
      plan_item(REQ_PEER_REQUEST, 5'd4, '1);
      case ($urandom_range(2))
         0: begin
            repeat (3) plan_item(REQ_PEER_LEAVING, 5'($urandom_range(31)), $urandom);
            plan_item(REQ_CLIENT_FINISHED, 5'd0, '0);
            plan_item(REQ_PEER_REQUEST, 5'd1, $urandom);
            plan_item(REQ_PEER_LEAVING, 5'd3, '1);
         end
         1: begin
            repeat (4) plan_item(REQ_PEER_LEAVING, 5'($urandom_range(31)), $urandom);
            plan_item(REQ_CLIENT_FINISHED, 5'd31, '1);
         end
         default: begin
            repeat (70) plan_item(REQ_PEER_LEAVING, 5'($urandom_range(31)), $urandom);
            plan_item(REQ_CLIENT_FINISHED, 5'd0, '0);
            plan_round();
            plan_item(REQ_PEER_LEAVING, 5'd1, '0);
         end
      endcase
      plan_item(REQ_CLIENT_REQUEST, 5'd0, '0);
      plan_item(REQ_PEER_PERMIT, 5'd1, '0);
      plan_item(REQ_PEER_REQUEST, 5'd1, '1);
      plan_item(REQ_CLIENT_RELEASE, 5'd0, '0);
      plan_item(REQ_CLIENT_FINISHED, 5'd0, '0);
      plan_item(REQ_PEER_LEAVING, 5'd1, '0);
      plan_item(REQ_RESERVED_A, 5'd0, '0);
      plan_item(REQ_RESERVED_B, 5'd0, '0);
      drain();

      if (fail_count == 0) begin
         $display("distributed_mutex_node_unit_tb passed");
      end else begin
         $display("distributed_mutex_node_unit_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("distributed_mutex_node_unit_tb failed");
      $finish;
   end

endmodule

// ===== distributed_mutex_node_unit.f =====
rtl/dmx_pkg.sv
rtl/dmx_ctrl.sv
rtl/dmx_dp.sv
rtl/distributed_mutex_node_unit.sv
test/distributed_mutex_node_unit_tb.sv
